### sv/psws_pkg.sv
// Shared constants and helpers for the packet size window statistics block.
// Used by psws_div and packet_size_window_stats; no dependencies.
`timescale 1ns / 1ps

package psws_pkg;

  localparam int WINDOW_DEF  = 1000;
  localparam int SIZE_W      = 16;
  localparam int MTU_W       = 16;
  localparam int QUOT_W      = 16;
  localparam int COUNT_OUT_W = 10;
  localparam int CFG_IDX_W   = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MTU = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MTU     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MTU     = 2'd2;

  localparam logic [MTU_W-1:0] CURRENT_MTU_RST = 16'd1500;
  localparam logic [MTU_W-1:0] MIN_MTU_RST     = 16'd576;
  localparam logic [MTU_W-1:0] MAX_MTU_RST     = 16'd65535;

  localparam logic [MTU_W-1:0] MTU_CLASS_0 = 16'd576;
  localparam logic [MTU_W-1:0] MTU_CLASS_1 = 16'd1280;
  localparam logic [MTU_W-1:0] MTU_CLASS_2 = 16'd1500;
  localparam logic [MTU_W-1:0] MTU_CLASS_3 = 16'd9000;

  localparam logic [MTU_W-1:0] GW_OVERHEAD = 16'd28;
  localparam logic [MTU_W-1:0] GW_FLOOR    = 16'd548;
  localparam logic [MTU_W-1:0] GW_MIN_MTU  = 16'd576;

  function automatic logic [MTU_W-1:0] round_to_class(input logic [SIZE_W-1:0] m,
                                                      input logic [MTU_W-1:0] max_mtu);
    logic [MTU_W-1:0] r;
    if (m <= MTU_CLASS_0)      r = MTU_CLASS_0;
    else if (m <= MTU_CLASS_1) r = MTU_CLASS_1;
    else if (m <= MTU_CLASS_2) r = MTU_CLASS_2;
    else if (m <= MTU_CLASS_3) r = MTU_CLASS_3;
    else                       r = max_mtu;
    return r;
  endfunction

endpackage

### sv/psws_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module psws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1000
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/psws_div.sv
// Iterative restoring divider, one quotient bit per cycle, 16-bit quotient.
// Depends on psws_pkg. The caller guarantees the quotient fits in QUOT_W bits.
`timescale 1ns / 1ps

module psws_div #(
  parameter int CNT_W = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [psws_pkg::SIZE_W+CNT_W-1:0]    dividend,
  input  logic [CNT_W-1:0]                     divisor,
  output logic                                 busy,
  output logic [psws_pkg::QUOT_W-1:0]          quotient
);

  localparam int W      = psws_pkg::SIZE_W + CNT_W;
  localparam int STEP_W = $clog2(psws_pkg::QUOT_W + 1);

  logic [W-1:0]      rem;
  logic [W-1:0]      dshift;
  logic [STEP_W-1:0] steps;
  logic              fits;

  assign fits = rem >= dshift;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(psws_pkg::QUOT_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dshift   <= W'(divisor) << (psws_pkg::QUOT_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dshift;
      end
      quotient <= {quotient[psws_pkg::QUOT_W-2:0], fits};
      dshift   <= dshift >> 1;
    end
  end

endmodule

### sv/packet_size_window_stats.sv
// Top level: sliding-window packet size statistics with sequencer, size ring,
// max deque and divider. Depends on psws_pkg, psws_ram, psws_div.
//
//  channel | signals                              | direction
//  in      | in_valid, in_ready, packet_size      | item in
//  out     | out_valid, out_ready, six fields     | item out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write
//
// One item passes S_RD1, then a back read (S_BRD) and compare (S_BCMP) for
// each entry dropped from the deque back, plus one when an entry stays, then
// S_PUSH, S_FVAL and S_WAIT; the divider for the average runs alongside the
// deque walk and S_WAIT holds until it is done. Reset is synchronous and
// needs no clearing pass. A finished result sits in the output register; the
// next item is taken while it waits, and its result then waits in S_WAIT
// until the output register frees up.
`timescale 1ns / 1ps

module packet_size_window_stats #(
  parameter int WINDOW = psws_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [psws_pkg::SIZE_W-1:0]         packet_size,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psws_pkg::SIZE_W-1:0]         window_max,
  output logic [psws_pkg::SIZE_W-1:0]         avg_size,
  output logic [psws_pkg::MTU_W-1:0]          optimal_mtu,
  output logic [psws_pkg::MTU_W-1:0]          gateway_mtu,
  output logic                                gateway_mtu_ok,
  output logic [psws_pkg::COUNT_OUT_W-1:0]    window_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psws_pkg::MTU_W-1:0]          cfg_data
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = psws_pkg::SIZE_W + CNT_W;
  localparam int DQ_W  = psws_pkg::SIZE_W + IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_BRD  = 3'd2;
  localparam logic [2:0] S_BCMP = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;
  localparam logic [2:0] S_FVAL = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  logic [2:0] state;

  logic [psws_pkg::MTU_W-1:0] current_mtu, min_mtu, max_mtu;

  logic [IDX_W-1:0] ring_head;
  logic [CNT_W-1:0] entry_count, cnt_next;
  logic [SUM_W-1:0] size_sum, sum_next;

  logic [IDX_W-1:0] dq_head, dq_tail, dq_last;
  logic [CNT_W-1:0] dq_cnt, dq_cnt_next;
  logic             push_empty;

  logic [psws_pkg::SIZE_W-1:0] size_q, wmax;

  logic [psws_pkg::SIZE_W-1:0] ring_rdata;
  logic [DQ_W-1:0]             dq_rdata;
  logic [IDX_W-1:0]            dq_raddr;
  logic                        full, pop_front;
  logic [psws_pkg::SIZE_W-1:0] back_val;
  logic [IDX_W-1:0]            front_slot;
  logic                        load_out;

  logic                        div_busy;
  logic [psws_pkg::QUOT_W-1:0] quotient;

  assign in_ready  = !rst && (state == S_IDLE);
  assign cfg_ready = !rst;

  assign full       = (entry_count == CNT_W'(WINDOW));
  assign front_slot = dq_rdata[IDX_W-1:0];
  assign back_val   = dq_rdata[DQ_W-1:IDX_W];
  assign dq_last    = (dq_tail == '0) ? LAST_IDX : dq_tail - 1'b1;
  assign pop_front  = full && (dq_cnt != '0) && (front_slot == ring_head);
  assign load_out   = (state == S_WAIT) && !div_busy && (!out_valid || out_ready);

  // window update done in S_RD1, once the oldest size has been read
  always_comb begin
    sum_next    = size_sum + SUM_W'(size_q);
    cnt_next    = entry_count + 1'b1;
    dq_cnt_next = dq_cnt;
    if (full) begin
      sum_next = size_sum - SUM_W'(ring_rdata) + SUM_W'(size_q);
      cnt_next = entry_count;
    end
    if (pop_front) begin
      dq_cnt_next = dq_cnt - 1'b1;
    end
  end

  always_comb begin
    dq_raddr = dq_head;
    if (state == S_BRD) begin
      dq_raddr = dq_last;
    end
  end

  psws_ram #(
    .WIDTH(psws_pkg::SIZE_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (state == S_RD1),
    .waddr(ring_head),
    .wdata(size_q),
    .raddr(ring_head),
    .rdata(ring_rdata)
  );

  // monotonic deque of {size, ring slot}; front holds the window maximum
  psws_ram #(
    .WIDTH(DQ_W),
    .DEPTH(WINDOW)
  ) u_deque (
    .clk  (clk),
    .we   (state == S_PUSH),
    .waddr(dq_tail),
    .wdata({size_q, ring_head}),
    .raddr(dq_raddr),
    .rdata(dq_rdata)
  );

  psws_div #(
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_RD1),
    .dividend(sum_next),
    .divisor (cnt_next),
    .busy    (div_busy),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mtu <= psws_pkg::CURRENT_MTU_RST;
      min_mtu     <= psws_pkg::MIN_MTU_RST;
      max_mtu     <= psws_pkg::MAX_MTU_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psws_pkg::REG_CURRENT_MTU: begin
          if (cfg_data >= min_mtu && cfg_data <= max_mtu) begin
            current_mtu <= cfg_data;
          end
        end
        psws_pkg::REG_MIN_MTU: min_mtu <= cfg_data;
        psws_pkg::REG_MAX_MTU: max_mtu <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ring_head   <= '0;
      entry_count <= '0;
      size_sum    <= '0;
      dq_head     <= '0;
      dq_tail     <= '0;
      dq_cnt      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            size_q <= packet_size;
            state  <= S_RD1;
          end
        end
        S_RD1: begin
          size_sum    <= sum_next;
          entry_count <= cnt_next;
          dq_cnt      <= dq_cnt_next;
          if (pop_front) begin
            dq_head <= (dq_head == LAST_IDX) ? '0 : dq_head + 1'b1;
          end
          state <= (dq_cnt_next == '0) ? S_PUSH : S_BRD;
        end
        S_BRD: begin
          state <= S_BCMP;
        end
        S_BCMP: begin
          if (back_val <= size_q) begin
            dq_tail <= dq_last;
            dq_cnt  <= dq_cnt - 1'b1;
            state   <= (dq_cnt == CNT_W'(1)) ? S_PUSH : S_BRD;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          push_empty <= (dq_cnt == '0);
          dq_tail    <= (dq_tail == LAST_IDX) ? '0 : dq_tail + 1'b1;
          dq_cnt     <= dq_cnt + 1'b1;
          ring_head  <= (ring_head == LAST_IDX) ? '0 : ring_head + 1'b1;
          state      <= S_FVAL;
        end
        S_FVAL: begin
          // front was read at dq_head during the push cycle
          wmax  <= push_empty ? size_q : dq_rdata[DQ_W-1:IDX_W];
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (load_out) begin
            window_max     <= wmax;
            avg_size       <= quotient;
            optimal_mtu    <= psws_pkg::round_to_class(wmax, max_mtu);
            gateway_mtu    <= (current_mtu >= psws_pkg::GW_MIN_MTU) ?
                              current_mtu - psws_pkg::GW_OVERHEAD : psws_pkg::GW_FLOOR;
            gateway_mtu_ok <= (current_mtu >= psws_pkg::GW_MIN_MTU) &&
                              (current_mtu <= max_mtu);
            window_count   <= psws_pkg::COUNT_OUT_W'(entry_count);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/psws_window_checker.sv
// Scoreboard for packet_size_window_stats: tracks register writes, predicts
// one statistics item per accepted packet size and compares the output items.
// Depends on psws_pkg.
`timescale 1ns / 1ps

module psws_window_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [psws_pkg::SIZE_W-1:0]      packet_size,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [psws_pkg::SIZE_W-1:0]      window_max,
  input  logic [psws_pkg::SIZE_W-1:0]      avg_size,
  input  logic [psws_pkg::MTU_W-1:0]       optimal_mtu,
  input  logic [psws_pkg::MTU_W-1:0]       gateway_mtu,
  input  logic                             gateway_mtu_ok,
  input  logic [psws_pkg::COUNT_OUT_W-1:0] window_count,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [psws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psws_pkg::MTU_W-1:0]       cfg_data,
  output int                               failures,
  output int                               pending_results
);

  localparam int WINDOW = psws_pkg::WINDOW_DEF;

  typedef struct packed {
    logic [psws_pkg::SIZE_W-1:0]      wmax;
    logic [psws_pkg::SIZE_W-1:0]      avg;
    logic [psws_pkg::MTU_W-1:0]       opt_mtu;
    logic [psws_pkg::MTU_W-1:0]       gw_mtu;
    logic                             gw_ok;
    logic [psws_pkg::COUNT_OUT_W-1:0] fill;
  } window_stats_t;

  logic [psws_pkg::SIZE_W-1:0] size_hist [WINDOW];
  int unsigned                 hist_head;
  int unsigned                 hist_fill;
  longint unsigned             size_total;
  logic [psws_pkg::MTU_W-1:0]  mtu_now;
  logic [psws_pkg::MTU_W-1:0]  mtu_floor;
  logic [psws_pkg::MTU_W-1:0]  mtu_ceil;

  window_stats_t stats_q [$];
  int            err_cnt = 0;

  // push one size into the window and work out the stats item it produces
  function automatic window_stats_t record_size(input logic [psws_pkg::SIZE_W-1:0] sz);
    window_stats_t               r;
    logic [psws_pkg::SIZE_W-1:0] peak;
    if (hist_fill >= WINDOW) begin
      size_total -= size_hist[hist_head];
    end else begin
      hist_fill++;
    end
    size_hist[hist_head] = sz;
    size_total += sz;
    hist_head = (hist_head + 1 == WINDOW) ? 0 : hist_head + 1;

    // until the ring wraps, the written slots are exactly 0..fill-1
    peak = '0;
    for (int unsigned j = 0; j < hist_fill; j++) begin
      if (size_hist[j] > peak) peak = size_hist[j];
    end

    r.wmax = peak;
    r.avg  = psws_pkg::SIZE_W'(size_total / hist_fill);
    if (peak > psws_pkg::MTU_CLASS_3)      r.opt_mtu = mtu_ceil;
    else if (peak > psws_pkg::MTU_CLASS_2) r.opt_mtu = psws_pkg::MTU_CLASS_3;
    else if (peak > psws_pkg::MTU_CLASS_1) r.opt_mtu = psws_pkg::MTU_CLASS_2;
    else if (peak > psws_pkg::MTU_CLASS_0) r.opt_mtu = psws_pkg::MTU_CLASS_1;
    else                                   r.opt_mtu = psws_pkg::MTU_CLASS_0;
    r.gw_mtu = (mtu_now >= psws_pkg::GW_MIN_MTU) ? mtu_now - psws_pkg::GW_OVERHEAD
                                                 : psws_pkg::GW_FLOOR;
    r.gw_ok  = (mtu_now >= psws_pkg::GW_MIN_MTU) && (mtu_now <= mtu_ceil);
    r.fill   = psws_pkg::COUNT_OUT_W'(hist_fill);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    window_stats_t want;
    if (rst) begin
      hist_head  = 0;
      hist_fill  = 0;
      size_total = 0;
      mtu_now    = psws_pkg::CURRENT_MTU_RST;
      mtu_floor  = psws_pkg::MIN_MTU_RST;
      mtu_ceil   = psws_pkg::MAX_MTU_RST;
      stats_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psws_pkg::REG_CURRENT_MTU: begin
            if (cfg_data >= mtu_floor && cfg_data <= mtu_ceil) mtu_now = cfg_data;
          end
          psws_pkg::REG_MIN_MTU: mtu_floor = cfg_data;
          psws_pkg::REG_MAX_MTU: mtu_ceil = cfg_data;
          default: ;  // unmapped index, write dropped
        endcase
      end

      // compare before queueing so an early item cannot hide behind a new one
      if (out_valid && out_ready) begin
        if (stats_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected output item, expected none actual max=%0d avg=%0d",
                   $time, window_max, avg_size);
        end else begin
          want = stats_q.pop_front();
          check_field("window_max", want.wmax, window_max);
          check_field("avg_size", want.avg, avg_size);
          check_field("optimal_mtu", want.opt_mtu, optimal_mtu);
          check_field("gateway_mtu", want.gw_mtu, gateway_mtu);
          check_field("gateway_mtu_ok", 16'(want.gw_ok), 16'(gateway_mtu_ok));
          check_field("window_count", 16'(want.fill), 16'(window_count));
        end
      end

      if (in_valid && in_ready) stats_q.insert(stats_q.size(), record_size(packet_size));
    end
    failures        <= err_cnt;
    pending_results <= stats_q.size();
  end

endmodule

### tb/sv/tb_packet_size_window_stats.sv
// Top of the packet_size_window_stats testbench: clock, reset, size and
// register stimulus, output back-pressure and the verdict.
// Depends on psws_pkg, packet_size_window_stats and psws_window_checker.
`timescale 1ns / 1ps

module tb_packet_size_window_stats;

  localparam logic [psws_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 185;
  localparam int QUIET_LO     = 600;
  localparam int QUIET_HI     = 800;
  localparam int HOLD_AT_A    = 150;
  localparam int HOLD_AT_B    = 1100;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 2 * psws_pkg::WINDOW_DEF + 50;
  localparam int CYCLE_LIMIT  = 30_000_000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [psws_pkg::SIZE_W-1:0]      packet_size = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [psws_pkg::SIZE_W-1:0]      window_max;
  logic [psws_pkg::SIZE_W-1:0]      avg_size;
  logic [psws_pkg::MTU_W-1:0]       optimal_mtu;
  logic [psws_pkg::MTU_W-1:0]       gateway_mtu;
  logic                             gateway_mtu_ok;
  logic [psws_pkg::COUNT_OUT_W-1:0] window_count;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [psws_pkg::CFG_IDX_W-1:0]   cfg_index = psws_pkg::REG_CURRENT_MTU;
  logic [psws_pkg::MTU_W-1:0]       cfg_data = '0;

  int failures;
  int pending_results;
  int sizes_sent    = 0;
  int results_taken = 0;
  int hold_left     = 0;
  bit hold_a_done   = 1'b0;
  bit hold_b_done   = 1'b0;
  int cycles        = 0;

  // ascending, so each boundary value becomes the window max in turn
  logic [psws_pkg::SIZE_W-1:0] edge_sizes [$] = '{16'd0, 16'd1, 16'd28, 16'd548, 16'd575,
                                                  16'd576, 16'd577, 16'd1279, 16'd1280,
                                                  16'd1281, 16'd1499, 16'd1500, 16'd1501,
                                                  16'd8999, 16'd9000, 16'd9001, 16'd21845,
                                                  16'd32768, 16'd43690, 16'd65534,
                                                  16'd65535};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  packet_size_window_stats i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .packet_size    (packet_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_max     (window_max),
    .avg_size       (avg_size),
    .optimal_mtu    (optimal_mtu),
    .gateway_mtu    (gateway_mtu),
    .gateway_mtu_ok (gateway_mtu_ok),
    .window_count   (window_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  psws_window_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .packet_size     (packet_size),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .window_max      (window_max),
    .avg_size        (avg_size),
    .optimal_mtu     (optimal_mtu),
    .gateway_mtu     (gateway_mtu),
    .gateway_mtu_ok  (gateway_mtu_ok),
    .window_count    (window_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .failures        (failures),
    .pending_results (pending_results)
  );

  // output side: random back-pressure, two long hold-offs, one quiet stretch
  always @(posedge clk) begin
    if (out_valid && out_ready) results_taken++;
    if (!hold_a_done && results_taken >= HOLD_AT_A) begin
      hold_a_done = 1'b1;
      hold_left   = HOLD_CYCLES;
    end
    if (!hold_b_done && results_taken >= HOLD_AT_B) begin
      hold_b_done = 1'b1;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (results_taken >= QUIET_LO && results_taken < QUIET_HI) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // valid stays high after a write; the caller drops it after the last one
  task automatic write_reg(input logic [psws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psws_pkg::MTU_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_size(input logic [psws_pkg::SIZE_W-1:0] sz);
    if (!(sizes_sent >= QUIET_LO && sizes_sent < QUIET_HI) && $urandom_range(0, 99) < 10)
    begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    packet_size <= sz;
    do @(posedge clk); while (!in_ready);
    sizes_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic apply_settings(input int phase);
    logic [psws_pkg::CFG_IDX_W-1:0] idx;
    logic [psws_pkg::MTU_W-1:0]     data;
    case (phase)
      0: begin
        // gateway floor path: current MTU below 576
        write_reg(psws_pkg::REG_MIN_MTU, 16'd0);
        write_reg(psws_pkg::REG_CURRENT_MTU, 16'd0);
        write_reg(REG_UNMAPPED, 16'h1234);
      end
      1: begin
        write_reg(psws_pkg::REG_CURRENT_MTU, 16'd576);
        write_reg(psws_pkg::REG_MAX_MTU, 16'd1000);
      end
      2: begin
        write_reg(psws_pkg::REG_CURRENT_MTU, 16'd2000);
        write_reg(psws_pkg::REG_MAX_MTU, 16'd0);
      end
      3: begin
        write_reg(psws_pkg::REG_MIN_MTU, 16'd65535);
        write_reg(psws_pkg::REG_MAX_MTU, 16'd65535);
        write_reg(psws_pkg::REG_CURRENT_MTU, 16'd65535);
        write_reg(psws_pkg::REG_CURRENT_MTU, 16'd65534);
      end
      4: begin
        // bounds crossed: every current MTU write is dropped
        write_reg(psws_pkg::REG_MIN_MTU, 16'd9000);
        write_reg(psws_pkg::REG_MAX_MTU, 16'd1500);
        write_reg(psws_pkg::REG_CURRENT_MTU, 16'd1500);
        write_reg(psws_pkg::REG_CURRENT_MTU, 16'd9000);
      end
      5: begin
        write_reg(psws_pkg::REG_MIN_MTU, psws_pkg::MIN_MTU_RST);
        write_reg(psws_pkg::REG_MAX_MTU, psws_pkg::MAX_MTU_RST);
        write_reg(psws_pkg::REG_CURRENT_MTU, psws_pkg::CURRENT_MTU_RST);
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 4)) inside
            0, 1: idx = psws_pkg::REG_CURRENT_MTU;
            2: idx = psws_pkg::REG_MIN_MTU;
            3: idx = psws_pkg::REG_MAX_MTU;
            default: idx = REG_UNMAPPED;
          endcase
          case ($urandom_range(0, 2))
            0: data = psws_pkg::MTU_W'($urandom_range(0, 65535));
            1: data = psws_pkg::MTU_W'($urandom_range(500, 1600));
            default: data = psws_pkg::MTU_W'($urandom_range(1400, 9500));
          endcase
          write_reg(idx, data);
        end
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // segments of one shape each: ramps drive the max tracking hardest
  task automatic random_sizes(input int count);
    int                          left;
    int                          seg;
    int                          shape;
    int                          near;
    logic [psws_pkg::SIZE_W-1:0] val;
    logic [psws_pkg::SIZE_W-1:0] stride;
    left = count;
    while (left > 0) begin
      shape  = $urandom_range(0, 9);
      seg    = $urandom_range(10, 60);
      val    = psws_pkg::SIZE_W'($urandom_range(0, 65535));
      stride = psws_pkg::SIZE_W'($urandom_range(1, 50));
      if (shape == 4) val = psws_pkg::SIZE_W'($urandom_range(0, 3000));
      if (seg > left) seg = left;
      repeat (seg) begin
        case (shape) inside
          0: val = psws_pkg::SIZE_W'($urandom_range(0, 65535));
          1, 2, 3: val = psws_pkg::SIZE_W'($urandom_range(0, 1600));
          4: val = val + stride;
          5: val = val - stride;
          6: ;  // constant run
          default: begin
            case ($urandom_range(0, 3))
              0: near = psws_pkg::MTU_CLASS_0;
              1: near = psws_pkg::MTU_CLASS_1;
              2: near = psws_pkg::MTU_CLASS_2;
              default: near = psws_pkg::MTU_CLASS_3;
            endcase
            val = psws_pkg::SIZE_W'(near + int'($urandom_range(0, 4)) - 2);
          end
        endcase
        send_size(val);
        left--;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (edge_sizes[k]) send_size(edge_sizes[k]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_settings(p);
      random_sizes(PHASE_ITEMS);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
sv/psws_pkg.sv
sv/psws_ram.sv
sv/psws_div.sv
sv/packet_size_window_stats.sv
tb/sv/psws_window_checker.sv
tb/sv/tb_packet_size_window_stats.sv
